FILE: rtl/clhf_pkg.sv
// Shared constants, types and helpers for the contact leg height fusion block.
`default_nettype none

package clhf_pkg;

  localparam int LEG_COUNT     = 4;
  localparam int FRACTION_BITS = 16;

  localparam int H_W    = 24;                               // height field width
  localparam int W_W    = FRACTION_BITS + 1;                // blend weight width
  localparam int MASK_W = LEG_COUNT;
  localparam int CNT_W  = $clog2(LEG_COUNT + 1);            // contact count
  localparam int SUM_W  = H_W + $clog2(LEG_COUNT);          // sum of heights
  localparam int D_W    = H_W + 1;                          // blend difference
  localparam int P_W    = W_W + 1 + D_W;                    // blend product
  localparam int ALU_W  = P_W - FRACTION_BITS + 1;          // shared adder width
  localparam int DIVC_W = $clog2(SUM_W + 1);                // divider bit counter

  localparam logic [W_W-1:0] BLEND_ONE   = W_W'(1 << FRACTION_BITS);
  localparam logic [W_W-1:0] BLEND_RESET = W_W'(64887);

  localparam int METHOD_W = 2;
  localparam logic [METHOD_W-1:0] METHOD_MEAN   = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_MEDIAN = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_MAX    = 2'd2;
  localparam logic [METHOD_W-1:0] METHOD_MIN    = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = W_W;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 1'd1;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

  typedef logic signed [H_W-1:0]   height_t;
  typedef logic signed [ALU_W-1:0] alu_t;

  function automatic alu_t ext_h(height_t v);
    return {{(ALU_W-H_W){v[H_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/clhf_if.sv
// Valid/ready channel interfaces for leg samples and fused height results.
`default_nettype none

interface clhf_in_if;
  logic                              valid;
  logic                              ready;
  clhf_pkg::height_t                 height_leg0;
  clhf_pkg::height_t                 height_leg1;
  clhf_pkg::height_t                 height_leg2;
  clhf_pkg::height_t                 height_leg3;
  logic [clhf_pkg::MASK_W-1:0]       contact_mask;

  modport source (output valid, height_leg0, height_leg1, height_leg2, height_leg3,
                  contact_mask, input ready);
  modport sink   (input valid, height_leg0, height_leg1, height_leg2, height_leg3,
                  contact_mask, output ready);
endinterface

interface clhf_out_if;
  logic              valid;
  logic              ready;
  clhf_pkg::height_t body_height;

  modport source (output valid, body_height, input ready);
  modport sink   (input valid, body_height, output ready);
endinterface

`default_nettype wire

FILE: rtl/clhf_alu.sv
// Shared add/subtract unit for arithmetic steps of the sequencer.
`default_nettype none

module clhf_alu (
  input  clhf_pkg::alu_op_t op,
  input  clhf_pkg::alu_t    a,
  input  clhf_pkg::alu_t    b,
  output clhf_pkg::alu_t    res
);

  always_comb begin
    unique case (op)
      clhf_pkg::ALU_ADD: res = a + b;
      clhf_pkg::ALU_SUB: res = a - b;
      default:           res = a + b;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/contact_leg_height_fusion_core.sv
// Contact-gated leg height fusion (mean/median/max/min) with first-order low-pass output.
// One transaction in, one transaction out. A single adder/subtractor is stepped by a
// sequencer; the block takes no new input until the current one has finished. After
// acceptance: with no leg in contact only the blend steps run; otherwise a serial bubble
// sort over a carry register and a shift line runs (9 compares, 2 regroups, 1 flush),
// then median/max/min run up to 3 rotations, one select/add, and difference, multiply,
// accumulate, and mean runs 4 summing steps, 1 magnitude, 26 restoring divide steps at
// one quotient bit per cycle, 1 sign and 3 blend steps. The divider makes the mean path
// the longest from one acceptance to the next. The finished height sits in an output
// register, so the next sample is taken while it waits to be collected.
`default_nettype none

module contact_leg_height_fusion_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  clhf_in_if.sink                               in_ch,
  clhf_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [clhf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [clhf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int L = clhf_pkg::LEG_COUNT;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SORT = 4'd1;
  localparam logic [3:0] ST_XFER = 4'd2;
  localparam logic [3:0] ST_FIN  = 4'd3;
  localparam logic [3:0] ST_SEEK = 4'd4;
  localparam logic [3:0] ST_MED  = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_ABS  = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_SIGN = 4'd9;
  localparam logic [3:0] ST_DIFF = 4'd10;
  localparam logic [3:0] ST_MUL  = 4'd11;
  localparam logic [3:0] ST_ACC  = 4'd12;

  logic [3:0]                          state_r;
  logic [clhf_pkg::METHOD_W-1:0]       method_r;
  logic [clhf_pkg::W_W-1:0]            blend_r;
  clhf_pkg::height_t                   last_r;
  logic                                out_valid_r;
  clhf_pkg::height_t                   out_body_r;

  // carry element and shift line of the serial sort
  logic                                cv_r;
  clhf_pkg::height_t                   ch_r;
  logic [L-1:0]                        qv_r;
  clhf_pkg::height_t                   qh_r [L];

  logic [clhf_pkg::CNT_W-1:0]          n_r;
  logic [clhf_pkg::CNT_W-1:0]          step_r;
  logic [clhf_pkg::CNT_W-1:0]          pass_r;
  logic signed [clhf_pkg::SUM_W-1:0]   acc_r;
  logic                                neg_r;
  logic [clhf_pkg::SUM_W-1:0]          mag_r;
  logic [clhf_pkg::CNT_W-1:0]          rem_r;
  logic [clhf_pkg::DIVC_W-1:0]         divc_r;
  clhf_pkg::height_t                   z_r;
  logic signed [clhf_pkg::D_W-1:0]     d_r;
  logic signed [clhf_pkg::P_W-1:0]     p_r;

  clhf_pkg::alu_op_t                   alu_op;
  clhf_pkg::alu_t                      alu_a;
  clhf_pkg::alu_t                      alu_b;
  clhf_pkg::alu_t                      alu_res;

  clhf_pkg::height_t                   in_h [L];
  logic [clhf_pkg::CNT_W-1:0]          in_cnt;
  logic                                in_acc;
  logic                                out_free;
  logic                                gt;
  logic [clhf_pkg::CNT_W-1:0]          tgt;
  logic [clhf_pkg::CNT_W:0]            trial;
  logic [clhf_pkg::W_W-1:0]            wsat;

  assign in_h[0] = in_ch.height_leg0;
  assign in_h[1] = in_ch.height_leg1;
  assign in_h[2] = in_ch.height_leg2;
  assign in_h[3] = in_ch.height_leg3;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.body_height = out_body_r;
  assign out_free        = !out_valid_r || out_ch.ready;

  assign wsat  = (blend_r > clhf_pkg::BLEND_ONE) ? clhf_pkg::BLEND_ONE : blend_r;
  assign trial = {rem_r, mag_r[clhf_pkg::SUM_W-1]};

  // carry is larger: missing contacts sort above every real height
  assign gt = (!cv_r && qv_r[0]) || ((cv_r == qv_r[0]) && alu_res[clhf_pkg::ALU_W-1]);

  always_comb begin
    in_cnt = '0;
    for (int i = 0; i < L; i++) begin
      in_cnt = in_cnt + clhf_pkg::CNT_W'(in_ch.contact_mask[i]);
    end
  end

  always_comb begin
    unique case (method_r)
      clhf_pkg::METHOD_MAX:    tgt = n_r - clhf_pkg::CNT_W'(1);
      clhf_pkg::METHOD_MEDIAN: tgt = (n_r - clhf_pkg::CNT_W'(1)) >> 1;
      default:                 tgt = '0;
    endcase
  end

  always_comb begin
    alu_op = clhf_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      ST_SORT: begin
        alu_op = clhf_pkg::ALU_SUB;
        alu_a  = clhf_pkg::ext_h(qh_r[0]);
        alu_b  = clhf_pkg::ext_h(ch_r);
      end
      ST_MED: begin
        alu_a = clhf_pkg::ext_h(qh_r[0]);
        alu_b = clhf_pkg::ext_h(qh_r[1]);
      end
      ST_SUM: begin
        alu_a = {{(clhf_pkg::ALU_W-clhf_pkg::SUM_W){acc_r[clhf_pkg::SUM_W-1]}}, acc_r};
        alu_b = qv_r[0] ? clhf_pkg::ext_h(qh_r[0]) : '0;
      end
      ST_ABS: begin
        alu_op = clhf_pkg::ALU_SUB;
        alu_b  = {{(clhf_pkg::ALU_W-clhf_pkg::SUM_W){acc_r[clhf_pkg::SUM_W-1]}}, acc_r};
      end
      ST_DIV: begin
        alu_op = clhf_pkg::ALU_SUB;
        alu_a  = {{(clhf_pkg::ALU_W-clhf_pkg::CNT_W-1){1'b0}}, trial};
        alu_b  = {{(clhf_pkg::ALU_W-clhf_pkg::CNT_W){1'b0}}, n_r};
      end
      ST_SIGN: begin
        alu_op = clhf_pkg::ALU_SUB;
        alu_b  = {{(clhf_pkg::ALU_W-clhf_pkg::SUM_W){1'b0}}, mag_r};
      end
      ST_DIFF: begin
        alu_op = clhf_pkg::ALU_SUB;
        alu_a  = clhf_pkg::ext_h(z_r);
        alu_b  = clhf_pkg::ext_h(last_r);
      end
      ST_ACC: begin
        alu_a = clhf_pkg::ext_h(last_r);
        alu_b = {p_r[clhf_pkg::P_W-1], p_r[clhf_pkg::P_W-1:clhf_pkg::FRACTION_BITS]};
      end
      default: begin
        alu_op = clhf_pkg::ALU_ADD;
      end
    endcase
  end

  clhf_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      method_r    <= clhf_pkg::METHOD_MEAN;
      blend_r     <= clhf_pkg::BLEND_RESET;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          clhf_pkg::CFG_METHOD: method_r <= cfg_wdata[clhf_pkg::METHOD_W-1:0];
          clhf_pkg::CFG_BLEND:  blend_r  <= cfg_wdata;
          default:              blend_r  <= blend_r;
        endcase
      end
      // the accumulate step reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != ST_ACC) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= (in_cnt == '0) ? ST_DIFF : ST_SORT;
          end
        end
        ST_SORT: begin
          if (step_r == clhf_pkg::CNT_W'(L - 1)) begin
            state_r <= (pass_r == clhf_pkg::CNT_W'(L - 2)) ? ST_FIN : ST_XFER;
          end
        end
        ST_XFER: state_r <= ST_SORT;
        ST_FIN: begin
          if (method_r == clhf_pkg::METHOD_MEAN) begin
            state_r <= ST_SUM;
          end else begin
            state_r <= (tgt == '0) ? ST_MED : ST_SEEK;
          end
        end
        ST_SEEK: begin
          if (step_r == clhf_pkg::CNT_W'(1)) begin
            state_r <= ST_MED;
          end
        end
        ST_MED: state_r <= ST_DIFF;
        ST_SUM: begin
          if (step_r == clhf_pkg::CNT_W'(L - 1)) begin
            state_r <= ST_ABS;
          end
        end
        ST_ABS: state_r <= ST_DIV;
        ST_DIV: begin
          if (divc_r == clhf_pkg::DIVC_W'(1)) begin
            state_r <= ST_SIGN;
          end
        end
        ST_SIGN: state_r <= ST_DIFF;
        ST_DIFF: state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_ACC;
        ST_ACC: begin
          // hold until the output register is free
          if (out_free) begin
            last_r      <= alu_res[clhf_pkg::H_W-1:0];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cv_r   <= in_ch.contact_mask[0];
          ch_r   <= in_h[0];
          for (int i = 0; i < L - 1; i++) begin
            qv_r[i] <= in_ch.contact_mask[i+1];
            qh_r[i] <= in_h[i+1];
          end
          qv_r[L-1] <= 1'b0;
          n_r    <= in_cnt;
          z_r    <= last_r;
          step_r <= clhf_pkg::CNT_W'(1);
          pass_r <= '0;
        end
      end
      ST_SORT: begin
        for (int i = 0; i < L - 1; i++) begin
          qv_r[i] <= qv_r[i+1];
          qh_r[i] <= qh_r[i+1];
        end
        qv_r[L-1] <= gt ? qv_r[0] : cv_r;
        qh_r[L-1] <= gt ? qh_r[0] : ch_r;
        if (!gt) begin
          cv_r <= qv_r[0];
          ch_r <= qh_r[0];
        end
        step_r <= step_r + clhf_pkg::CNT_W'(1);
        if (step_r == clhf_pkg::CNT_W'(L - 1)) begin
          pass_r <= pass_r + clhf_pkg::CNT_W'(1);
        end
      end
      ST_XFER: begin
        // drop the empty head slot, restart the carry, park the pass maximum
        cv_r <= qv_r[1];
        ch_r <= qh_r[1];
        for (int i = 0; i < L - 2; i++) begin
          qv_r[i] <= qv_r[i+2];
          qh_r[i] <= qh_r[i+2];
        end
        qv_r[L-2] <= cv_r;
        qh_r[L-2] <= ch_r;
        step_r    <= clhf_pkg::CNT_W'(1);
      end
      ST_FIN: begin
        for (int i = 0; i < L - 1; i++) begin
          qv_r[i] <= qv_r[i+1];
          qh_r[i] <= qh_r[i+1];
        end
        qv_r[L-1] <= cv_r;
        qh_r[L-1] <= ch_r;
        acc_r     <= '0;
        step_r    <= (method_r == clhf_pkg::METHOD_MEAN) ? '0 : tgt;
      end
      ST_SEEK, ST_SUM: begin
        for (int i = 0; i < L - 1; i++) begin
          qv_r[i] <= qv_r[i+1];
          qh_r[i] <= qh_r[i+1];
        end
        qv_r[L-1] <= qv_r[0];
        qh_r[L-1] <= qh_r[0];
        if (state_r == ST_SUM) begin
          acc_r  <= alu_res[clhf_pkg::SUM_W-1:0];
          step_r <= step_r + clhf_pkg::CNT_W'(1);
        end else begin
          step_r <= step_r - clhf_pkg::CNT_W'(1);
        end
      end
      ST_MED: begin
        if (method_r == clhf_pkg::METHOD_MEDIAN && !n_r[0]) begin
          z_r <= alu_res[clhf_pkg::H_W:1];
        end else begin
          z_r <= qh_r[0];
        end
      end
      ST_ABS: begin
        neg_r  <= acc_r[clhf_pkg::SUM_W-1];
        mag_r  <= acc_r[clhf_pkg::SUM_W-1] ? alu_res[clhf_pkg::SUM_W-1:0] : acc_r;
        rem_r  <= '0;
        divc_r <= clhf_pkg::DIVC_W'(clhf_pkg::SUM_W);
      end
      ST_DIV: begin
        // restoring step: quotient bits shift in behind the dividend
        if (!alu_res[clhf_pkg::ALU_W-1]) begin
          rem_r <= alu_res[clhf_pkg::CNT_W-1:0];
        end else begin
          rem_r <= trial[clhf_pkg::CNT_W-1:0];
        end
        mag_r  <= {mag_r[clhf_pkg::SUM_W-2:0], !alu_res[clhf_pkg::ALU_W-1]};
        divc_r <= divc_r - clhf_pkg::DIVC_W'(1);
      end
      ST_SIGN: begin
        z_r <= neg_r ? alu_res[clhf_pkg::H_W-1:0] : mag_r[clhf_pkg::H_W-1:0];
      end
      ST_DIFF: d_r <= alu_res[clhf_pkg::D_W-1:0];
      ST_MUL:  p_r <= signed'({1'b0, wsat}) * d_r;
      ST_ACC: begin
        if (out_free) begin
          out_body_r <= alu_res[clhf_pkg::H_W-1:0];
        end
      end
      default: begin
        z_r <= z_r;
      end
    endcase
  end

  // checks
  a_div_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < n_r)
    else $error("divider remainder not below contact count");

  a_sort_packs_contacts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> qv_r[0] && ($countones(qv_r) == int'(n_r)))
    else $error("sorted line does not hold the contacting legs first");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("new transaction taken right after acceptance");

  a_output_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && out_free) |=> out_valid_r && (out_body_r == last_r))
    else $error("emitted height differs from stored filter state");

endmodule

`default_nettype wire

FILE: dv/contact_leg_height_fusion_core_test.sv
// Self-checking testbench for the contact leg height fusion core.
`timescale 1ns / 100ps

module contact_leg_height_fusion_core_test;

  localparam int H_MAX = (1 << (clhf_pkg::H_W - 1)) - 1;
  localparam int H_MIN = -(1 << (clhf_pkg::H_W - 1));
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    clhf_pkg::height_t [clhf_pkg::LEG_COUNT-1:0] leg;
    logic [clhf_pkg::MASK_W-1:0]                 mask;
  } leg_sample_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [clhf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [clhf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  clhf_in_if  in_ch ();
  clhf_out_if out_ch ();

  contact_leg_height_fusion_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state and its copy of the configuration
  logic [clhf_pkg::METHOD_W-1:0] method_sel;
  logic [clhf_pkg::W_W-1:0]      blend_w;
  clhf_pkg::height_t             filt_height;

  leg_sample_t       pending_samples[$];
  clhf_pkg::height_t expected_heights[$];
  leg_sample_t cur_sample;
  logic        sample_loaded;
  int          burst_left;
  int          gap_left;
  int          errors;
  int          results_seen;
  int          hold_left;
  logic        hold_done;
  int          stall_mode;
  int          mode_left;

  function automatic clhf_pkg::height_t fuse_height(leg_sample_t s);
    longint legs[clhf_pkg::LEG_COUNT];
    longint t, z, w, acc;
    int n, i, j;
    n = 0;
    for (i = 0; i < clhf_pkg::LEG_COUNT; i++) begin
      if (s.mask[i]) begin
        legs[n] = longint'(s.leg[i]);
        n++;
      end
    end
    // sort ascending so median, max and min are positional
    for (i = 1; i < n; i++) begin
      for (j = i; j > 0; j--) begin
        if (legs[j-1] > legs[j]) begin
          t = legs[j-1];
          legs[j-1] = legs[j];
          legs[j] = t;
        end
      end
    end
    if (n == 0) begin
      z = longint'(filt_height);
    end else begin
      case (method_sel)
        clhf_pkg::METHOD_MEAN: begin
          acc = 0;
          for (i = 0; i < n; i++) acc += legs[i];
          z = acc / n;
        end
        clhf_pkg::METHOD_MEDIAN: begin
          if (n % 2 == 0) z = (legs[n/2-1] + legs[n/2]) >>> 1;
          else z = legs[n/2];
        end
        clhf_pkg::METHOD_MAX: z = legs[n-1];
        default: z = legs[0];
      endcase
    end
    w = (blend_w > clhf_pkg::BLEND_ONE) ? longint'(clhf_pkg::BLEND_ONE) : longint'(blend_w);
    acc = w * z + (longint'(clhf_pkg::BLEND_ONE) - w) * longint'(filt_height);
    filt_height = clhf_pkg::height_t'(acc >>> clhf_pkg::FRACTION_BITS);
    return filt_height;
  endfunction

  function automatic clhf_pkg::height_t rand_height();
    case ($urandom_range(0, 7))
      0: return clhf_pkg::height_t'(H_MAX);
      1: return clhf_pkg::height_t'(H_MIN);
      2: return $urandom_range(0, 1) ? clhf_pkg::height_t'(0) : clhf_pkg::height_t'(-1);
      3, 4: return clhf_pkg::height_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return clhf_pkg::height_t'($urandom);
    endcase
  endfunction

  function automatic leg_sample_t rand_sample();
    leg_sample_t s;
    int i;
    for (i = 0; i < clhf_pkg::LEG_COUNT; i++) s.leg[i] = rand_height();
    s.mask = ($urandom_range(0, 9) == 0) ? '0 : clhf_pkg::MASK_W'($urandom_range(1, 15));
    return s;
  endfunction

  // Junk in the unused upper bits of a method write
  function automatic logic [clhf_pkg::CFG_DATA_W-1:0] method_word(
      logic [clhf_pkg::METHOD_W-1:0] m);
    return {(clhf_pkg::CFG_DATA_W-clhf_pkg::METHOD_W)'($urandom), m};
  endfunction

  task automatic add_sample(int h0, int h1, int h2, int h3,
                            logic [clhf_pkg::MASK_W-1:0] mask);
    leg_sample_t s;
    s.leg[0] = clhf_pkg::height_t'(h0);
    s.leg[1] = clhf_pkg::height_t'(h1);
    s.leg[2] = clhf_pkg::height_t'(h2);
    s.leg[3] = clhf_pkg::height_t'(h3);
    s.mask = mask;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || sample_loaded || expected_heights.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [clhf_pkg::CFG_IDX_W-1:0] idx,
                           logic [clhf_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == clhf_pkg::CFG_METHOD) method_sel = data[clhf_pkg::METHOD_W-1:0];
    else blend_w = data[clhf_pkg::W_W-1:0];
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      sample_loaded = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_heights.insert(expected_heights.size(), fuse_height(cur_sample));
        sample_loaded = 1'b0;
      end
      if (!sample_loaded) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          cur_sample = pending_samples.pop_front();
          sample_loaded = 1'b1;
          in_ch.height_leg0  <= cur_sample.leg[0];
          in_ch.height_leg1  <= cur_sample.leg[1];
          in_ch.height_leg2  <= cur_sample.leg[2];
          in_ch.height_leg3  <= cur_sample.leg[3];
          in_ch.contact_mask <= cur_sample.mask;
          in_ch.valid        <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transaction, stall on modes of its own plus one long hold-off
  always @(posedge clk) begin
    clhf_pkg::height_t exp_h;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_heights.size() == 0) begin
          errors++;
          $display("%0t: body_height expected none got %0d", $time, out_ch.body_height);
        end else begin
          exp_h = expected_heights.pop_front();
          if (out_ch.body_height !== exp_h) begin
            errors++;
            $display("%0t: body_height expected %0d got %0d", $time, exp_h,
                     out_ch.body_height);
          end
        end
      end
      if (!hold_done && results_seen >= 150) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    int p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.height_leg0 = '0;
    in_ch.height_leg1 = '0;
    in_ch.height_leg2 = '0;
    in_ch.height_leg3 = '0;
    in_ch.contact_mask = '0;
    out_ch.ready = 1'b0;
    sample_loaded = 1'b0;
    burst_left = 0;
    gap_left = 0;
    errors = 0;
    results_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    stall_mode = 0;
    mode_left = 0;
    method_sel = clhf_pkg::METHOD_MEAN;
    blend_w = clhf_pkg::BLEND_RESET;
    filt_height = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Mean at reset settings: extremes, truncation toward zero, no contact
    add_sample(H_MAX, H_MAX, H_MAX, H_MAX, 4'b1111);
    add_sample(H_MIN, H_MIN, H_MIN, H_MIN, 4'b1111);
    add_sample(-1, -1, -2, 7, 4'b0111);
    add_sample(5, 2, 100, -100, 4'b0011);
    add_sample(H_MAX, H_MIN, 1, 1, 4'b0000);
    add_sample(H_MAX, H_MIN, 123, -456, 4'b1010);
    wait_idle();

    // Median with full weight: even count rounds down, odd count, single leg
    write_reg(clhf_pkg::CFG_METHOD, method_word(clhf_pkg::METHOD_MEDIAN));
    write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(clhf_pkg::BLEND_ONE));
    add_sample(10, -3, -2, 100, 4'b0110);
    add_sample(9, 1, 5, -7, 4'b1111);
    add_sample(4, 8, -6, 0, 4'b1011);
    add_sample(H_MAX, H_MAX, H_MIN, 0, 4'b0011);
    add_sample(H_MIN, H_MIN, 3, H_MIN, 4'b1100);
    add_sample(77, 77, 77, H_MAX, 4'b1000);
    add_sample(1, 2, 3, 4, 4'b0000);
    wait_idle();

    // Maximum with a weight above one, which saturates
    write_reg(clhf_pkg::CFG_METHOD, method_word(clhf_pkg::METHOD_MAX));
    write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(clhf_pkg::BLEND_ONE + 1));
    add_sample(-5, 300, H_MIN, 299, 4'b1111);
    add_sample(-50, -40, -30, -20, 4'b0101);
    add_sample(H_MAX, H_MAX, H_MAX, H_MAX, 4'b0000);
    wait_idle();

    // Minimum with zero weight, then with the largest weight
    write_reg(clhf_pkg::CFG_METHOD, method_word(clhf_pkg::METHOD_MIN));
    write_reg(clhf_pkg::CFG_BLEND, '0);
    add_sample(8, -9, 10, -11, 4'b1111);
    add_sample(H_MIN, H_MIN, H_MAX, H_MIN, 4'b0100);
    wait_idle();
    write_reg(clhf_pkg::CFG_BLEND, '1);
    add_sample(H_MAX, -2, H_MIN, 0, 4'b1111);
    add_sample(H_MAX, 0, 0, H_MIN, 4'b1001);
    wait_idle();

    write_reg(clhf_pkg::CFG_METHOD, method_word(clhf_pkg::METHOD_MEAN));
    write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(1));
    add_sample(H_MIN, H_MAX, H_MIN, H_MIN, 4'b1101);
    add_sample(0, 0, 0, 0, 4'b0000);

    for (p = 0; p < 9; p++) begin
      wait_idle();
      write_reg(clhf_pkg::CFG_METHOD, method_word(clhf_pkg::METHOD_W'(p)));
      case (p)
        0: write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(65535));
        1: write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(1));
        2: write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(clhf_pkg::BLEND_ONE));
        3: write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(32768));
        4: write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'($urandom_range(0, 65536)));
        5: write_reg(clhf_pkg::CFG_BLEND, '1);
        6: write_reg(clhf_pkg::CFG_BLEND, clhf_pkg::CFG_DATA_W'(clhf_pkg::BLEND_RESET));
        7: write_reg(clhf_pkg::CFG_BLEND,
                     clhf_pkg::CFG_DATA_W'($urandom_range(65537, 131071)));
        default: write_reg(clhf_pkg::CFG_BLEND,
                           clhf_pkg::CFG_DATA_W'($urandom_range(0, 65536)));
      endcase
      repeat (50) pending_samples.insert(pending_samples.size(), rand_sample());
    end
    wait_idle();
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("contact_leg_height_fusion_core_test OK");
    end else begin
      $display("contact_leg_height_fusion_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("contact_leg_height_fusion_core_test NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/clhf_pkg.sv
rtl/clhf_if.sv
rtl/clhf_alu.sv
rtl/contact_leg_height_fusion_core.sv
dv/contact_leg_height_fusion_core_test.sv
